// File: hw/rtl/jeita_temperature_charge_limiter_core_macros.svh
// Assertion macros shared by the charge limiter RTL.
`ifndef JEITA_TEMPERATURE_CHARGE_LIMITER_CORE_MACROS_SVH
`define JEITA_TEMPERATURE_CHARGE_LIMITER_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define JTCL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define JTCL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/jtcl_pkg.sv
// Shared types and constants of the temperature charge limiter.
package jtcl_pkg;

    localparam int JTCL_ENTRIES = 6;

    localparam int TEMP_W  = 12;
    localparam int VALUE_W = 24;
    localparam int HYST_W  = 10;
    localparam int EIDX_W  = 3;
    localparam int CFG_W   = 12;
    localparam int GATE_W  = 5;

    // Input operation codes.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_HOT  = 2'd0;
    localparam logic [1:0] REG_COLD = 2'd1;
    localparam logic [1:0] REG_RISE = 2'd2;
    localparam logic [1:0] REG_FALL = 2'd3;

    // Hysteresis only applies below this entry on the way up and from this
    // entry on the way down.
    localparam logic [GATE_W-1:0] RISE_GATE = 5'd5;
    localparam logic [GATE_W-1:0] FALL_GATE = 5'd4;

    localparam logic signed [TEMP_W-1:0] HOT_RESET  = 12'sd2047;
    localparam logic signed [TEMP_W-1:0] COLD_RESET = -12'sd2048;

    typedef struct packed {
        logic                     op;
        logic signed [TEMP_W-1:0] temperature;
        logic                     table_select;
        logic [EIDX_W-1:0]        entry_index;
        logic signed [TEMP_W-1:0] entry_low;
        logic signed [TEMP_W-1:0] entry_high;
        logic [VALUE_W-1:0]       entry_value;
    } jtcl_req_t;

    typedef struct packed {
        logic [VALUE_W-1:0] current_limit;
        logic               current_index_valid;
        logic [EIDX_W-1:0]  current_entry;
        logic [VALUE_W-1:0] voltage_limit;
        logic               voltage_index_valid;
        logic [EIDX_W-1:0]  voltage_entry;
        logic               charge_disabled;
    } jtcl_rsp_t;

    typedef struct packed {
        logic tbl;
        logic load_sample;
        logic write_entry;
        logic scan;
        logic hyst;
        logic fetch;
        logic load_out;
    } jtcl_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } jtcl_status_t;

endpackage

// File: hw/rtl/jtcl_ctrl.sv
// Sequencing controller of the temperature charge limiter.
module jtcl_ctrl
    import jtcl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    input  logic         req_op,
    input  jtcl_status_t status,
    output logic         req_stall,
    output jtcl_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_HYST  = 5'b00100,
        ST_FETCH = 5'b01000,
        ST_DONE  = 5'b10000
    } jtcl_state_t;

    jtcl_state_t state_reg, state_next;
    logic        tbl_reg, tbl_next;
    logic        accept;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        tbl_next        = tbl_reg;
        cmd             = '0;
        cmd.tbl         = tbl_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_op == OP_WRITE)
                    begin
                        cmd.write_entry = 1'b1;
                    end
                    else
                    begin
                        cmd.load_sample = 1'b1;
                        tbl_next        = 1'b0;
                        state_next      = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_HYST;
                end
            end
            ST_HYST:
            begin
                cmd.hyst   = 1'b1;
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                cmd.fetch = 1'b1;
                if (tbl_reg == 1'b0)
                begin
                    tbl_next   = 1'b1;
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tbl_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tbl_reg   <= tbl_next;
        end
    end

endmodule

// File: hw/rtl/jtcl_datapath.sv
// Table storage, scan, hysteresis and result registers of the charge limiter.
module jtcl_datapath
    import jtcl_pkg::*;
#(
    parameter int ENTRIES = JTCL_ENTRIES
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [1:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  jtcl_req_t          req_data,
    input  logic               rsp_stall,
    input  jtcl_cmd_t          cmd,
    output jtcl_status_t       status,
    output logic               rsp_valid,
    output jtcl_rsp_t          rsp_data
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = IDX_W + 1;
    localparam int SLOTS  = 2 * ENTRIES;
    localparam int ADDR_W = $clog2(SLOTS);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(ENTRIES - 1);
    localparam logic [ADDR_W-1:0] TBL1_BASE = ADDR_W'(ENTRIES);
    localparam logic [CNT_W-1:0]  ENT_CNT   = CNT_W'(ENTRIES);

    // Configuration registers.
    logic signed [TEMP_W-1:0] hot_reg, cold_reg;
    logic [HYST_W-1:0]        rise_reg, fall_reg;

    // Range tables, both tables in one flat store.
    logic signed [TEMP_W-1:0] low_reg   [SLOTS];
    logic signed [TEMP_W-1:0] high_reg  [SLOTS];
    logic [VALUE_W-1:0]       value_reg [SLOTS];

    logic signed [TEMP_W-1:0] t_reg;
    logic                     disabled_reg;
    logic [IDX_W-1:0]         scan_idx_reg;
    logic signed [TEMP_W-1:0] sel_lo_reg, sel_hi_reg;
    logic [IDX_W-1:0]         sel_idx_reg;
    logic                     found_reg;
    logic                     pos_valid_reg [2];
    logic [IDX_W-1:0]         pos_idx_reg   [2];
    logic [VALUE_W-1:0]       limit_reg     [2];
    logic                     rsp_valid_reg;
    jtcl_rsp_t                rsp_reg;

    logic                     wr_ok;
    logic [ADDR_W-1:0]        wr_addr;
    logic [IDX_W-1:0]         rd_idx;
    logic [ADDR_W-1:0]        rd_addr;
    logic signed [TEMP_W-1:0] rd_lo, rd_hi;
    logic [VALUE_W-1:0]       rd_value;
    logic                     below, empty, hit, last;
    logic                     held_valid;
    logic [IDX_W-1:0]         held_idx;
    logic [CNT_W-1:0]         sel_c, held_c;
    logic                     step_up, step_dn, keep;
    logic signed [TEMP_W:0]   t_ext, rise_thr, fall_thr;
    logic [GATE_W-1:0]        sel_g;
    logic [IDX_W-1:0]         final_idx;
    logic                     sample_disable, gate_ok;

    // Write path.
    assign wr_ok   = (CNT_W'(req_data.entry_index) < ENT_CNT);
    assign wr_addr = (req_data.table_select ? TBL1_BASE : '0) + ADDR_W'(req_data.entry_index);

    // Single read port: the scan pointer, or the chosen entry when fetching.
    assign rd_idx   = cmd.fetch ? pos_idx_reg[cmd.tbl] : scan_idx_reg;
    assign rd_addr  = (cmd.tbl ? TBL1_BASE : '0) + ADDR_W'(rd_idx);
    assign rd_lo    = low_reg[rd_addr];
    assign rd_hi    = high_reg[rd_addr];
    assign rd_value = value_reg[rd_addr];

    // Scan step classification.
    assign below = (scan_idx_reg == '0) && (t_reg < rd_lo);
    assign empty = (rd_lo == '0) && (rd_hi == '0);
    assign hit   = (rd_lo < rd_hi) ? ((t_reg >= rd_lo) && (t_reg <= rd_hi))
                                   : ((t_reg >= rd_hi) && (t_reg <= rd_lo));
    assign last  = (scan_idx_reg == LAST_IDX);
    assign status.scan_done = below || empty || hit || last;
    assign status.out_free  = !rsp_valid_reg || !rsp_stall;

    // Hysteresis against the index held from the previous sample.
    assign held_valid = pos_valid_reg[cmd.tbl];
    assign held_idx   = pos_idx_reg[cmd.tbl];
    assign sel_c      = CNT_W'(sel_idx_reg);
    assign held_c     = CNT_W'(held_idx);
    assign step_up    = held_valid && (sel_c == held_c + CNT_W'(1));
    assign step_dn    = held_valid && (sel_c + CNT_W'(1) == held_c);
    assign t_ext      = {t_reg[TEMP_W-1], t_reg};
    assign rise_thr   = $signed({sel_lo_reg[TEMP_W-1], sel_lo_reg})
                      + $signed({3'b000, rise_reg});
    assign fall_thr   = $signed({sel_hi_reg[TEMP_W-1], sel_hi_reg})
                      - $signed({3'b000, fall_reg});
    assign sel_g      = GATE_W'(sel_idx_reg);
    assign keep       = (step_up && (t_ext < rise_thr) && (sel_g < RISE_GATE))
                     || (step_dn && (t_ext > fall_thr) && (sel_g >= FALL_GATE));
    assign final_idx  = keep ? held_idx : sel_idx_reg;

    // The disable flag only moves while the thresholds straddle zero.
    assign gate_ok        = !hot_reg[TEMP_W-1] && (cold_reg[TEMP_W-1] || (cold_reg == '0));
    assign sample_disable = (req_data.temperature >= hot_reg)
                         || (req_data.temperature <= cold_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hot_reg  <= HOT_RESET;
            cold_reg <= COLD_RESET;
            rise_reg <= '0;
            fall_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_HOT:  hot_reg  <= cfg_data;
                REG_COLD: cold_reg <= cfg_data;
                REG_RISE: rise_reg <= cfg_data[HYST_W-1:0];
                REG_FALL: fall_reg <= cfg_data[HYST_W-1:0];
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                low_reg[i]   <= '0;
                high_reg[i]  <= '0;
                value_reg[i] <= '0;
            end
        end
        else if (cmd.write_entry && wr_ok)
        begin
            low_reg[wr_addr]   <= req_data.entry_low;
            high_reg[wr_addr]  <= req_data.entry_high;
            value_reg[wr_addr] <= req_data.entry_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disabled_reg  <= 1'b0;
            scan_idx_reg  <= '0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
            for (int k = 0; k < 2; k++)
            begin
                pos_valid_reg[k] <= 1'b0;
                pos_idx_reg[k]   <= '0;
            end
        end
        else
        begin
            if (cmd.load_sample)
            begin
                scan_idx_reg <= '0;
                if (gate_ok)
                begin
                    disabled_reg <= sample_disable;
                end
            end
            if (cmd.scan)
            begin
                if (status.scan_done)
                begin
                    found_reg <= !below && !(empty && (scan_idx_reg == '0));
                end
                else
                begin
                    scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                end
            end
            if (cmd.hyst)
            begin
                pos_valid_reg[cmd.tbl] <= found_reg;
                pos_idx_reg[cmd.tbl]   <= found_reg ? final_idx : '0;
            end
            if (cmd.fetch)
            begin
                scan_idx_reg <= '0;
            end
            if (cmd.load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            t_reg <= req_data.temperature;
        end
        if (cmd.scan && !below && !empty)
        begin
            sel_lo_reg  <= rd_lo;
            sel_hi_reg  <= rd_hi;
            sel_idx_reg <= scan_idx_reg;
        end
        if (cmd.fetch)
        begin
            limit_reg[cmd.tbl] <= pos_valid_reg[cmd.tbl] ? rd_value : '0;
        end
        if (cmd.load_out)
        begin
            rsp_reg.current_limit       <= limit_reg[0];
            rsp_reg.current_index_valid <= pos_valid_reg[0];
            rsp_reg.current_entry       <= pos_idx_reg[0][EIDX_W-1:0];
            rsp_reg.voltage_limit       <= limit_reg[1];
            rsp_reg.voltage_index_valid <= pos_valid_reg[1];
            rsp_reg.voltage_entry       <= pos_idx_reg[1][EIDX_W-1:0];
            rsp_reg.charge_disabled     <= disabled_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

// File: hw/rtl/jeita_temperature_charge_limiter_core.sv
// Top level of the temperature charge limiter with hysteresis.
//
// Usage: beats on the request channel (req_valid, req_stall, req_data) either
// write one entry of the current or the voltage range table (op = write) or
// carry a temperature sample (op = sample). A write takes effect at its own
// beat and gives no response; the block stays ready the next cycle.
// A sample gives exactly one response beat (rsp_valid, rsp_stall, rsp_data)
// holding the selected current and voltage limits, their indexes and the
// charge disable flag.
// The two tables are scanned one after the other, one entry per cycle,
// through a single read port on the table store; each scan visits 1 to
// ENTRIES entries. The request side is stalled while a sample is in work,
// until its result is loaded into the output register.
// If the receiver stalls, the finished response waits in the output register
// and a new sample may still be taken; it then waits before its own result
// is loaded. Reset clears both tables, the held indexes, the disable flag
// and loads the threshold and hysteresis registers with their defaults.
`include "jeita_temperature_charge_limiter_core_macros.svh"

module jeita_temperature_charge_limiter_core
    import jtcl_pkg::*;
#(
    parameter int ENTRIES = JTCL_ENTRIES
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write_en,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             req_valid,
    output logic             req_stall,
    input  jtcl_req_t        req_data,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output jtcl_rsp_t        rsp_data
);

    jtcl_cmd_t    cmd;
    jtcl_status_t status;

    // The controller owns sequencing; the datapath owns all storage.
    jtcl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_op    (req_data.op),
        .status    (status),
        .req_stall (req_stall),
        .cmd       (cmd)
    );

    jtcl_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_data     (req_data),
        .rsp_stall    (rsp_stall),
        .cmd          (cmd),
        .status       (status),
        .rsp_valid    (rsp_valid),
        .rsp_data     (rsp_data)
    );

    // A sample beat always makes the block busy in the following cycle.
    `JTCL_ASSERT_NEXT(a_sample_busy, clk, rst_n, req_valid && !req_stall && (req_data.op == OP_SAMPLE), req_stall, "sample beat did not start a lookup")

    // A table write completes in its own beat.
    `JTCL_ASSERT_NEXT(a_write_single, clk, rst_n, req_valid && !req_stall && (req_data.op == OP_WRITE), !req_stall, "table write held the request side")

    // An invalid current index reports entry zero and no limit.
    `JTCL_ASSERT_IMP(a_cur_invalid, clk, rst_n, rsp_valid && !rsp_data.current_index_valid, (rsp_data.current_entry == '0) && (rsp_data.current_limit == '0), "invalid current index with data")

    // An invalid voltage index reports entry zero and no limit.
    `JTCL_ASSERT_IMP(a_vol_invalid, clk, rst_n, rsp_valid && !rsp_data.voltage_index_valid, (rsp_data.voltage_entry == '0) && (rsp_data.voltage_limit == '0), "invalid voltage index with data")

endmodule

// File: dv/tb_jeita_temperature_charge_limiter_core.sv
// Self-checking testbench of the temperature charge limiter with range tables and hysteresis.
`timescale 1ns / 1ps

module tb_jeita_temperature_charge_limiter_core;
    import jtcl_pkg::*;

    // Enough settling time for the block to fall idle after the longest sample.
    localparam int SETTLE_CYCLES  = 2 * JTCL_ENTRIES + 8;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT    = 5000;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 62;
    localparam int REPORT_LIMIT   = 10;

    // Threshold and hysteresis settings of the first five phases; the last phase
    // draws its own.
    localparam int HOT_SET  [PHASES] = '{2047,   450,    0,   -1, 2047, 0};
    localparam int COLD_SET [PHASES] = '{-2048, -100,    0, -2048,   1, 0};
    localparam int RISE_SET [PHASES] = '{0,       30, 1023,   50,   15, 0};
    localparam int FALL_SET [PHASES] = '{0,       30, 1023,   70,   60, 0};

    typedef struct {
        jtcl_req_t item;
        bit        fixed_want;   // the expected result is given in the row itself
        jtcl_rsp_t want;
    } directed_row_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_write_en;
    logic [1:0]       cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             req_valid;
    logic             req_stall;
    jtcl_req_t        req_data;
    logic             rsp_valid;
    logic             rsp_stall;
    jtcl_rsp_t        rsp_data;

    // Own copy of the block state: both range tables side by side, the index each
    // table holds between samples, the disable flag and the four registers.
    int                 entry_lo   [2 * JTCL_ENTRIES];
    int                 entry_hi   [2 * JTCL_ENTRIES];
    logic [VALUE_W-1:0] entry_val  [2 * JTCL_ENTRIES];
    bit                 held_valid [2];
    int                 held_index [2];
    bit                 charge_blocked;
    int                 hot_limit;
    int                 cold_limit;
    int                 rise_margin;
    int                 fall_margin;

    // Results that are owed by the block, oldest first.
    jtcl_rsp_t expected_limits[$];

    int failures      = 0;
    int send_idle_pct = 17;
    int rsp_idle_pct  = 57;
    int hold_requests = 0;

    jeita_temperature_charge_limiter_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req_data     (req_data),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .rsp_data     (rsp_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Only the first few failures are printed in full; the rest are merely counted.
    task automatic report_failure(input string msg);
        failures++;
        if (failures <= REPORT_LIMIT)
        begin
            $display("[%0t] %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            report_failure($sformatf("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got));
        end
    endtask

    // Looks up one table as the block does. The scan takes the first entry whose
    // bounds enclose the temperature, in either order of the bounds, stops at an
    // entry with both bounds zero and otherwise clips to the last entry scanned.
    // Stepping to a neighbouring entry is then held back by the rise or fall
    // margin, the rise margin only below entry five and the fall margin only when
    // stepping down to entry four or above.
    function automatic void pick_entry(input int tbl, input int temp,
                                       output logic [VALUE_W-1:0] value,
                                       output logic index_ok,
                                       output logic [EIDX_W-1:0] chosen);
        int base;
        int i;
        int sel;
        bit found;
        bit was_valid;
        int was_index;

        base      = tbl * JTCL_ENTRIES;
        found     = 1'b0;
        sel       = 0;
        was_valid = held_valid[tbl];
        was_index = held_index[tbl];
        value     = '0;
        index_ok  = 1'b0;
        chosen    = '0;
        held_valid[tbl] = 1'b0;
        held_index[tbl] = 0;

        if (temp < entry_lo[base])
        begin
            return;
        end
        for (i = 0; i < JTCL_ENTRIES; i++)
        begin
            if (entry_lo[base + i] == 0 && entry_hi[base + i] == 0)
            begin
                break;
            end
            if ((temp >= entry_lo[base + i] && temp <= entry_hi[base + i]) ||
                (temp >= entry_hi[base + i] && temp <= entry_lo[base + i]))
            begin
                found = 1'b1;
                sel   = i;
                break;
            end
        end
        if (!found)
        begin
            if (i == 0)
            begin
                return;
            end
            sel = i - 1;
        end

        if (was_valid)
        begin
            if (sel == was_index + 1)
            begin
                if (temp < entry_lo[base + sel] + rise_margin && sel < int'(RISE_GATE))
                begin
                    sel = was_index;
                end
            end
            else if (was_index > 0 && sel == was_index - 1)
            begin
                if (temp > entry_hi[base + sel] - fall_margin && sel >= int'(FALL_GATE))
                begin
                    sel = was_index;
                end
            end
        end

        held_valid[tbl] = 1'b1;
        held_index[tbl] = sel;
        value    = entry_val[base + sel];
        index_ok = 1'b1;
        chosen   = EIDX_W'(sel);
    endfunction

    // Works out the result of one temperature sample and advances the state.
    function automatic jtcl_rsp_t select_limits(input logic signed [TEMP_W-1:0] sample);
        jtcl_rsp_t r;
        int t;

        t = int'(sample);
        // The flag is frozen while the thresholds do not straddle zero.
        if (hot_limit >= 0 && cold_limit <= 0)
        begin
            charge_blocked = (t >= hot_limit || t <= cold_limit);
        end
        pick_entry(0, t, r.current_limit, r.current_index_valid, r.current_entry);
        pick_entry(1, t, r.voltage_limit, r.voltage_index_valid, r.voltage_entry);
        r.charge_disabled = charge_blocked;
        return r;
    endfunction

    function automatic jtcl_req_t sample_item(input int temp);
        jtcl_req_t r;

        // Fields that a sample does not use carry random values.
        r.op           = OP_SAMPLE;
        r.temperature  = TEMP_W'(temp);
        r.table_select = 1'($urandom);
        r.entry_index  = EIDX_W'($urandom);
        r.entry_low    = TEMP_W'($urandom);
        r.entry_high   = TEMP_W'($urandom);
        r.entry_value  = VALUE_W'($urandom);
        return r;
    endfunction

    function automatic jtcl_req_t write_item(input int tbl, input int idx, input int lo,
                                             input int hi, input logic [VALUE_W-1:0] value);
        jtcl_req_t r;

        r.op           = OP_WRITE;
        r.temperature  = TEMP_W'($urandom);
        r.table_select = 1'(tbl);
        r.entry_index  = EIDX_W'(idx);
        r.entry_low    = TEMP_W'(lo);
        r.entry_high   = TEMP_W'(hi);
        r.entry_value  = value;
        return r;
    endfunction

    // Offers one request beat, with random gaps ahead of it, and holds it until the
    // block takes it. The prediction is made at the accepting edge, long before the
    // block can answer.
    task automatic send_beat(input jtcl_req_t item, input bit fixed_want = 1'b0,
                             input jtcl_rsp_t want = '0);
        jtcl_rsp_t predicted;
        int k;

        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= item;
        do
        begin
            @(posedge clk);
        end
        while (req_stall);

        if (item.op == OP_SAMPLE)
        begin
            predicted = select_limits(item.temperature);
            expected_limits.push_back(fixed_want ? want : predicted);
        end
        else if (int'(item.entry_index) < JTCL_ENTRIES)
        begin
            // Entries are stored as given, and the held indexes are left alone.
            k = int'(item.table_select) * JTCL_ENTRIES + int'(item.entry_index);
            entry_lo[k]  = int'(item.entry_low);
            entry_hi[k]  = int'(item.entry_high);
            entry_val[k] = item.entry_value;
        end
    endtask

    // Writes one register. The enable is left high so that back-to-back writes
    // need only one assignment per edge; the caller lowers it afterwards.
    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(posedge clk);
        case (idx)
            REG_HOT:  hot_limit   = int'($signed(data));
            REG_COLD: cold_limit  = int'($signed(data));
            REG_RISE: rise_margin = int'(data[HYST_W-1:0]);
            REG_FALL: fall_margin = int'(data[HYST_W-1:0]);
            default:  ;
        endcase
    endtask

    // Receiver: random stalls, or a long hold-off whenever the stimulus asks for one
    // so that a finished result backs up and the request side is stalled.
    initial
    begin : response_sink
        int hold_left;
        int hold_seen;

        hold_left = 0;
        hold_seen = 0;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
            end
        end
    end

    // Every accepted response beat is compared field by field with the oldest
    // expected result.
    initial
    begin : response_check
        jtcl_rsp_t want;
        jtcl_rsp_t got;

        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
            begin
                got = rsp_data;
                if (expected_limits.size() == 0)
                begin
                    report_failure($sformatf("response beat 0x%0h with nothing expected", got));
                end
                else
                begin
                    want = expected_limits.pop_front();
                    check_field("current_limit", 32'(want.current_limit),
                                32'(got.current_limit));
                    check_field("current_index_valid", 32'(want.current_index_valid),
                                32'(got.current_index_valid));
                    check_field("current_entry", 32'(want.current_entry),
                                32'(got.current_entry));
                    check_field("voltage_limit", 32'(want.voltage_limit),
                                32'(got.voltage_limit));
                    check_field("voltage_index_valid", 32'(want.voltage_index_valid),
                                32'(got.voltage_index_valid));
                    check_field("voltage_entry", 32'(want.voltage_entry),
                                32'(got.voltage_entry));
                    check_field("charge_disabled", 32'(want.charge_disabled),
                                32'(got.charge_disabled));
                end
            end
        end
    end

    // Watchdog: the run is ended once no beat has moved on either channel for too
    // long. The longest correct pause is the receiver's hold-off, well below this.
    initial
    begin : watchdog
        int quiet;

        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        directed_row_t rows[$];
        jtcl_req_t     item;
        int            span_lo;
        int            span_hi;
        int            start;
        int            used;
        int            lo;
        int            hi;
        int            swap;
        int            walk;
        int            walk_dir;
        int            hot_cfg;
        int            cold_cfg;
        int            rise_cfg;
        int            fall_cfg;

        rst_n        <= 1'b0;
        cfg_write_en <= 1'b0;
        cfg_index    <= REG_HOT;
        cfg_data     <= '0;
        req_valid    <= 1'b0;
        req_data     <= '0;

        // State after reset: empty tables, no held index, flag clear, default registers.
        for (int k = 0; k < 2 * JTCL_ENTRIES; k++)
        begin
            entry_lo[k]  = 0;
            entry_hi[k]  = 0;
            entry_val[k] = '0;
        end
        held_valid     = '{1'b0, 1'b0};
        held_index     = '{0, 0};
        charge_blocked = 1'b0;
        hot_limit      = int'(HOT_RESET);
        cold_limit     = int'(COLD_RESET);
        rise_margin    = 0;
        fall_margin    = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. With empty tables every sample gives no data, and with the
        // default thresholds only the two temperature extremes disable charging.
        rows.push_back(directed_row_t'{sample_item(0), 1'b1,
                                       jtcl_rsp_t'{charge_disabled: 1'b0, default: '0}});
        rows.push_back(directed_row_t'{sample_item(2047), 1'b1,
                                       jtcl_rsp_t'{charge_disabled: 1'b1, default: '0}});
        rows.push_back(directed_row_t'{sample_item(-2048), 1'b1,
                                       jtcl_rsp_t'{charge_disabled: 1'b1, default: '0}});
        // Current table: six entries, the third with its bounds reversed.
        rows.push_back(directed_row_t'{write_item(0, 0, -400, -1, 24'hFFFFFF), 1'b0, '0});
        rows.push_back(directed_row_t'{write_item(0, 1, 0, 149, 24'd1500), 1'b0, '0});
        rows.push_back(directed_row_t'{write_item(0, 2, 299, 150, 24'd1000), 1'b0, '0});
        rows.push_back(directed_row_t'{write_item(0, 3, 300, 449, 24'd700), 1'b0, '0});
        rows.push_back(directed_row_t'{write_item(0, 4, 450, 599, 24'd300), 1'b0, '0});
        rows.push_back(directed_row_t'{write_item(0, 5, 600, 2047, 24'd0), 1'b0, '0});
        // Writes past the last entry must leave both tables untouched.
        rows.push_back(directed_row_t'{write_item(0, 6, -2048, 2047, 24'hFFFFFF), 1'b0, '0});
        rows.push_back(directed_row_t'{write_item(1, 7, 2047, -2048, 24'd0), 1'b0, '0});
        // Voltage table: two entries closed by an all-zero entry.
        rows.push_back(directed_row_t'{write_item(1, 0, -300, 99, 24'd4200000), 1'b0, '0});
        rows.push_back(directed_row_t'{write_item(1, 1, 100, 399, 24'd4100000), 1'b0, '0});
        rows.push_back(directed_row_t'{write_item(1, 2, 0, 0, 24'd0), 1'b0, '0});
        // The hottest sample matches the last current entry and clips the voltage
        // table to its last entry before the terminator.
        rows.push_back(directed_row_t'{sample_item(2047), 1'b1,
                                       jtcl_rsp_t'{current_limit: 24'd0,
                                                   current_index_valid: 1'b1,
                                                   current_entry: 3'd5,
                                                   voltage_limit: 24'd4100000,
                                                   voltage_index_valid: 1'b1,
                                                   voltage_entry: 3'd1,
                                                   charge_disabled: 1'b1}});
        // The coldest sample lies below the first bound of both tables.
        rows.push_back(directed_row_t'{sample_item(-2048), 1'b1,
                                       jtcl_rsp_t'{charge_disabled: 1'b1, default: '0}});
        rows.push_back(directed_row_t'{sample_item(-350), 1'b0, '0});
        rows.push_back(directed_row_t'{sample_item(120), 1'b0, '0});
        rows.push_back(directed_row_t'{sample_item(200), 1'b0, '0});
        rows.push_back(directed_row_t'{sample_item(500), 1'b0, '0});
        rows.push_back(directed_row_t'{sample_item(1000), 1'b0, '0});
        rows.push_back(directed_row_t'{sample_item(449), 1'b0, '0});
        rows.push_back(directed_row_t'{sample_item(100), 1'b0, '0});
        rows.push_back(directed_row_t'{sample_item(-1), 1'b0, '0});

        foreach (rows[r])
        begin
            send_beat(rows[r].item, rows[r].fixed_want, rows[r].want);
        end

        span_lo  = 0;
        span_hi  = 0;
        walk     = 0;
        walk_dir = 1;

        for (int phase = 0; phase < PHASES; phase++)
        begin
            // The sender waits for every owed result, and the block is given time to
            // fall idle before its registers change.
            req_valid <= 1'b0;
            while (expected_limits.size() != 0)
            begin
                @(posedge clk);
            end
            repeat (SETTLE_CYCLES) @(posedge clk);

            // Sender dense and receiver often stalling first, then the reverse, then no gaps.
            if (phase < 2)
            begin
                send_idle_pct = 17;
                rsp_idle_pct <= 57;
            end
            else if (phase < 4)
            begin
                send_idle_pct = 57;
                rsp_idle_pct <= 17;
            end
            else
            begin
                send_idle_pct = 0;
                rsp_idle_pct <= 0;
            end

            if (phase == PHASES - 1)
            begin
                hot_cfg  = int'($signed(12'($urandom)));
                cold_cfg = int'($signed(12'($urandom)));
                rise_cfg = int'($urandom_range(0, 120));
                fall_cfg = int'($urandom_range(0, 120));
            end
            else
            begin
                hot_cfg  = HOT_SET[phase];
                cold_cfg = COLD_SET[phase];
                rise_cfg = RISE_SET[phase];
                fall_cfg = FALL_SET[phase];
            end
            // The upper bits of a hysteresis write are junk and must be dropped.
            write_reg(REG_HOT, CFG_W'(hot_cfg));
            write_reg(REG_COLD, CFG_W'(cold_cfg));
            write_reg(REG_RISE, {2'($urandom), HYST_W'(rise_cfg)});
            write_reg(REG_FALL, {2'($urandom), HYST_W'(fall_cfg)});
            cfg_write_en <= 1'b0;

            // Fresh tables of ascending ranges, now and then with a gap or reversed
            // bounds, closed by an all-zero entry when shorter than the table. The
            // entries behind the terminator hold junk that the scan must not reach.
            for (int tsel = 0; tsel < 2; tsel++)
            begin
                if (tsel == 0)
                begin
                    start   = int'($urandom_range(0, 600)) - 600;
                    span_lo = start;
                end
                else
                begin
                    start = span_lo + int'($urandom_range(0, 100)) - 50;
                end
                used = int'($urandom_range(1, JTCL_ENTRIES));
                for (int k = 0; k < JTCL_ENTRIES; k++)
                begin
                    if (k < used)
                    begin
                        lo    = start;
                        hi    = start + int'($urandom_range(20, 200)) - 1;
                        start = hi + 1;
                        if ($urandom_range(0, 99) < 20)
                        begin
                            start += int'($urandom_range(1, 40));
                        end
                        if (tsel == 0)
                        begin
                            span_hi = hi;
                        end
                        if ($urandom_range(0, 99) < 20)
                        begin
                            swap = lo;
                            lo   = hi;
                            hi   = swap;
                        end
                        item = write_item(tsel, k, lo, hi, VALUE_W'($urandom));
                    end
                    else if (k == used)
                    begin
                        item = write_item(tsel, k, 0, 0, '0);
                    end
                    else
                    begin
                        item = write_item(tsel, k, int'($signed(12'($urandom))),
                                          int'($signed(12'($urandom))), VALUE_W'($urandom));
                    end
                    send_beat(item);
                end
            end

            // Mostly a temperature that wanders up and down through the tables, so
            // that the held indexes step between neighbours and the hysteresis bites;
            // the rest is jumps anywhere in the range and stray entry writes.
            walk = span_lo;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 4 && n == 10)
                begin
                    hold_requests <= hold_requests + 1;
                end
                if ($urandom_range(0, 99) < 6)
                begin
                    item = write_item(int'($urandom_range(0, 1)), int'($urandom_range(0, 7)),
                                      int'($signed(12'($urandom))),
                                      int'($signed(12'($urandom))), VALUE_W'($urandom));
                end
                else if ($urandom_range(0, 99) < 10)
                begin
                    item = sample_item(int'($signed(12'($urandom))));
                end
                else
                begin
                    if ($urandom_range(0, 99) < 5)
                    begin
                        walk_dir = -walk_dir;
                    end
                    walk += walk_dir * int'($urandom_range(0, 24));
                    if (walk > span_hi + 60)
                    begin
                        walk_dir = -1;
                    end
                    if (walk < span_lo - 60)
                    begin
                        walk_dir = 1;
                    end
                    if (walk > 2047)
                    begin
                        walk = 2047;
                    end
                    if (walk < -2048)
                    begin
                        walk = -2048;
                    end
                    item = sample_item(walk);
                end
                send_beat(item);
            end
        end

        req_valid <= 1'b0;
        while (expected_limits.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (failures == 0 && expected_limits.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
